// ===== design/sha_pkg.sv =====
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_word_t;

  typedef logic [31:0] word32_t;

  localparam word32_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word32_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word32_t rotr(word32_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== design/sha_if.sv =====
interface sha_in_if;
  logic              valid;
  logic              ready;
  sha_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if;
  logic               valid;
  logic               ready;
  sha_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/sha_round.sv =====
// One SHA-256 round plus the schedule update, reused for all 64 rounds.
module sha_round (
  input  sha_pkg::word32_t va [8],
  input  sha_pkg::word32_t w_j,
  input  sha_pkg::word32_t w_j1,
  input  sha_pkg::word32_t w_j9,
  input  sha_pkg::word32_t w_j14,
  input  logic             expand,
  input  logic [5:0]       round,
  output sha_pkg::word32_t vn [8],
  output sha_pkg::word32_t w_new
);
  sha_pkg::word32_t s0w, s1w, w, s1, ch, t1, s0, mj, t2;

  always_comb begin
    s0w = sha_pkg::rotr(w_j1, 7) ^ sha_pkg::rotr(w_j1, 18) ^ (w_j1 >> 3);
    s1w = sha_pkg::rotr(w_j14, 17) ^ sha_pkg::rotr(w_j14, 19) ^ (w_j14 >> 10);
    w = expand ? (w_j + s0w + w_j9 + s1w) : w_j;
    w_new = w;
    s1 = sha_pkg::rotr(va[4], 6) ^ sha_pkg::rotr(va[4], 11) ^ sha_pkg::rotr(va[4], 25);
    ch = (va[4] & va[5]) ^ (~va[4] & va[6]);
    t1 = va[7] + s1 + ch + sha_pkg::ROUND_K[round] + w;
    s0 = sha_pkg::rotr(va[0], 2) ^ sha_pkg::rotr(va[0], 13) ^ sha_pkg::rotr(va[0], 22);
    mj = (va[0] & va[1]) ^ (va[0] & va[2]) ^ (va[1] & va[2]);
    t2 = s0 + mj;
    vn[7] = va[6];
    vn[6] = va[5];
    vn[5] = va[4];
    vn[4] = va[3] + t1;
    vn[3] = va[2];
    vn[2] = va[1];
    vn[1] = va[0];
    vn[0] = t1 + t2;
  end
endmodule

// ===== design/sha256_message_digest.sv =====
// SHA-256 message digest, one message byte per input word.
// in: data_byte with byte_present, plus message_end. A byte lands in the
// current 64-byte block; the 64th byte starts compression. message_end pads
// the block (0x80, zeros, 64-bit bit length), compresses once or twice and
// then sends four 64-bit digest words on out, word 0 most significant,
// last_word set on word 3. The chaining state then returns to the initial hash.
// A byte that does not fill the block is taken in S_IDLE, and in_ready stays
// high. A full block runs the rounds on the shared round unit and then folds
// into the chain with in_ready low, so no byte is taken while a block
// compresses. An end word runs one or two such compressions and then sends
// the digest words; a stalled receiver holds the digest word in the output
// register and the block waits.
// Reset (synchronous, rst_n low) loads the initial hash, clears counts and
// drops any digest in flight.
module sha256_message_digest (
  input  logic          clk,
  input  logic          rst_n,
  sha_in_if.sink        in_ch,
  sha_out_if.source     out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_LEN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  sha_pkg::word32_t hash_r [8];
  sha_pkg::word32_t blk_r [16];
  sha_pkg::word32_t va_r [8];
  sha_pkg::word32_t vn [8];
  sha_pkg::word32_t w_new;
  logic [5:0]       fill_r;
  logic [60:0]      total_r;
  logic [5:0]       round_r;
  logic             fin_r;   // message end pending
  logic             len_r;   // length block still to compress
  logic [1:0]       oidx_r;
  logic             ovalid_r;
  logic [3:0]       j;
  logic [63:0]      bits;

  assign j = round_r[3:0];
  assign bits = {total_r, 3'b000};

  sha_round u_round (
    .va(va_r), .w_j(blk_r[j]), .w_j1(blk_r[j + 4'd1]), .w_j9(blk_r[j + 4'd9]),
    .w_j14(blk_r[j + 4'd14]), .expand(round_r[5] | round_r[4]), .round(round_r),
    .vn(vn), .w_new(w_new)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data.digest_word = {hash_r[{oidx_r, 1'b0}], hash_r[{oidx_r, 1'b1}]};
  assign out_ch.data.word_index = oidx_r;
  assign out_ch.data.last_word = (oidx_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      // start compression on a message end or on the byte that fills the block
      S_IDLE:  state_nxt = (in_ch.valid && (in_ch.data.message_end ||
                            (in_ch.data.byte_present && fill_r == 6'd63))) ? S_ROUND : S_IDLE;
      S_ROUND: state_nxt = (round_r == 6'd63) ? S_FOLD : S_ROUND;
      S_FOLD:  state_nxt = len_r ? S_LEN : (fin_r ? S_OUT : S_IDLE);
      S_LEN:   state_nxt = S_ROUND;
      S_OUT:   state_nxt = (out_ch.ready && oidx_r == 2'd3) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hash_r <= sha_pkg::INIT_HASH;
      for (int i = 0; i < 16; i++) blk_r[i] <= '0;
      fill_r <= '0;
      total_r <= '0;
      round_r <= '0;
      fin_r <= 1'b0;
      len_r <= 1'b0;
      oidx_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            logic [5:0]  f;
            logic [60:0] tot;
            logic        full;
            sha_pkg::word32_t b [16];
            b = blk_r;
            f = fill_r;
            tot = total_r;
            full = 1'b0;
            if (in_ch.data.byte_present) begin
              if (f[1:0] == 2'd0) b[f[5:2]] = '0;
              b[f[5:2]][(5'd3 - {3'd0, f[1:0]}) * 8 +: 8] = in_ch.data.data_byte;
              f = f + 6'd1;
              tot = tot + 61'd1;
              full = (f == 6'd0);
            end
            total_r <= tot;
            fill_r <= f;
            fin_r <= in_ch.data.message_end;
            if (in_ch.data.message_end && !full) begin
              // pad: 0x80 then zeros through the end of the block
              if (f[1:0] == 2'd0) b[f[5:2]] = '0;
              b[f[5:2]][(5'd3 - {3'd0, f[1:0]}) * 8 +: 8] = sha_pkg::PAD_BYTE;
              for (int w = 0; w < 16; w++)
                if (4'(w) > f[5:2]) b[w] = '0;
              if (f >= 6'd56) begin
                len_r <= 1'b1;
              end else begin
                len_r <= 1'b0;
                b[14] = tot[60:29];
                b[15] = {tot[28:0], 3'b000};
              end
              va_r <= hash_r;
              round_r <= '0;
            end else if (full) begin
              // a full block compresses; with an end pending, the padding goes in a fresh block
              len_r <= in_ch.data.message_end;
              va_r <= hash_r;
              round_r <= '0;
            end
            blk_r <= b;
          end
        end
        S_ROUND: begin
          va_r <= vn;
          blk_r[j] <= w_new;
          round_r <= round_r + 6'd1;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + va_r[i];
          for (int i = 0; i < 16; i++) blk_r[i] <= '0;
          if (!len_r && fin_r) begin
            ovalid_r <= 1'b1;
            oidx_r <= '0;
          end
        end
        S_LEN: begin
          // second block: either 0x80 leads (block was exactly full) or zeros
          blk_r[0] <= (fill_r == 6'd0) ? {sha_pkg::PAD_BYTE, 24'd0} : '0;
          for (int i = 1; i < 14; i++) blk_r[i] <= '0;
          blk_r[14] <= bits[63:32];
          blk_r[15] <= bits[31:0];
          len_r <= 1'b0;
          va_r <= hash_r;
          round_r <= '0;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            oidx_r <= oidx_r + 2'd1;
            if (oidx_r == 2'd3) begin
              ovalid_r <= 1'b0;
              fin_r <= 1'b0;
              hash_r <= sha_pkg::INIT_HASH;
              fill_r <= '0;
              total_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_message_digest uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // digest predictor state
  sha_pkg::word32_t hash_st [8];
  sha_pkg::word32_t blk_st [16];
  logic [5:0]       fill_st;
  logic [60:0]      len_st;

  sha_pkg::out_word_t digest_q [$];
  int        fail_cnt;
  int        burst_left;
  int        stall_phase;

  function automatic sha_pkg::word32_t ror(sha_pkg::word32_t x, int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_compress();
    sha_pkg::word32_t v [8];
    sha_pkg::word32_t x15, x2, s0, s1, t1, t2, ch, mj;
    int j;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int r = 0; r < 64; r++) begin
      j = r & 15;
      if (r >= 16) begin
        x15 = blk_st[(j + 1) & 15];
        x2 = blk_st[(j + 14) & 15];
        s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        blk_st[j] = blk_st[j] + s0 + blk_st[(j + 9) & 15] + s1;
      end
      s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha_pkg::ROUND_K[r] + blk_st[j];
      s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    for (int i = 0; i < 16; i++) blk_st[i] = '0;
  endtask

  task automatic place_byte(logic [5:0] pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) blk_st[pos[5:2]] = '0;
    blk_st[pos[5:2]] |= sha_pkg::word32_t'(b) << ((3 - pos[1:0]) * 8);
  endtask

  task automatic clear_msg();
    for (int i = 0; i < 8; i++) hash_st[i] = sha_pkg::INIT_HASH[i];
    for (int i = 0; i < 16; i++) blk_st[i] = '0;
    fill_st = '0;
    len_st = '0;
  endtask

  task automatic predict_digest(sha_pkg::in_word_t w);
    logic [63:0] bits;
    sha_pkg::out_word_t o;
    if (w.byte_present) begin
      place_byte(fill_st, w.data_byte);
      fill_st++;
      len_st++;
      if (fill_st == 0) run_compress();
    end
    if (!w.message_end) return;
    place_byte(fill_st, sha_pkg::PAD_BYTE);
    for (int k = fill_st[5:2] + 1; k < 16; k++) blk_st[k] = '0;
    if (fill_st >= 56) run_compress();
    bits = {len_st, 3'b000};
    blk_st[14] = bits[63:32];
    blk_st[15] = bits[31:0];
    run_compress();
    for (int i = 0; i < 4; i++) begin
      o.digest_word = {hash_st[2 * i], hash_st[2 * i + 1]};
      o.word_index = 2'(i);
      o.last_word = (i == 3);
      digest_q.push_back(o);
    end
    clear_msg();
  endtask

  // send one word; the sender sends in bursts with random gaps
  task automatic send_word(logic [7:0] b, logic bp, logic me);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= '{data_byte: b, byte_present: bp, message_end: me};
    do @(posedge clk); while (!in_ch.ready);
    predict_digest('{data_byte: b, byte_present: bp, message_end: me});
  endtask

  task automatic send_message(int len, logic last_has_byte);
    for (int i = 0; i < len - 1; i++) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    if (len > 0) send_word(8'($urandom_range(0, 255)), last_has_byte, 1'b1);
    else send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);            // empty message
    send_word(8'hff, 1'b0, 1'b0);            // idle word, byte ignored
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);            // "abc"
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);            // end without a byte
    wait_drained();
  endtask

  task automatic test_pad_edges();
    // 56 bytes push the length into a second block; 64 fills exactly
    send_message(56, 1'b1);
    send_message(64, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 10) begin
      len = $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        sent += 1;
      end
      send_message(len, 1'($urandom_range(0, 1)));
      sent += len + 1;
    end
  endtask

  // receiver stalls at random, but is always ready in a rotating phase
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    out_ch.ready <= (stall_phase[5:4] == 2'd3) ? 1'b1 : (($urandom & 3) != 0);
  end

  always @(posedge clk) begin
    sha_pkg::out_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual %h", $time, out_ch.data);
        fail_cnt++;
      end else begin
        exp_w = digest_q.pop_front();
        if (out_ch.data.digest_word !== exp_w.digest_word) begin
          $display("%0t digest_word: expected %h, actual %h", $time,
                   exp_w.digest_word, out_ch.data.digest_word);
          fail_cnt++;
        end
        if (out_ch.data.word_index !== exp_w.word_index) begin
          $display("%0t word_index: expected %0d, actual %0d", $time,
                   exp_w.word_index, out_ch.data.word_index);
          fail_cnt++;
        end
        if (out_ch.data.last_word !== exp_w.last_word) begin
          $display("%0t last_word: expected %0d, actual %0d", $time,
                   exp_w.last_word, out_ch.data.last_word);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    fail_cnt = 0;
    burst_left = 0;
    stall_phase = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    clear_msg();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pad_edges();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/sha_pkg.sv
design/sha_if.sv
design/sha_round.sv
design/sha256_message_digest.sv
verif/testbench.sv
